// ----- hdl/weighted_measurement_combiner_top_macros.svh -----
// assertion macros for the weighted measurement combiner
`ifndef WEIGHTED_MEASUREMENT_COMBINER_TOP_MACROS_SVH
`define WEIGHTED_MEASUREMENT_COMBINER_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define WMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define WMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/wmc_pkg.sv -----
// package with shared types and constants of the weighted measurement combiner
package wmc_pkg;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned ACC_W   = 64;

    typedef struct packed {
        logic signed [VALUE_W-1:0] meas_value;
        logic [VALUE_W-1:0]        stat_error;
        logic [VALUE_W-1:0]        syst_error;
        logic                      last_in_group;
    } t_meas;

    typedef struct packed {
        logic signed [VALUE_W-1:0] weighted_mean;
        logic [VALUE_W-1:0]        stat_uncertainty;
        logic [VALUE_W-1:0]        syst_uncertainty;
        logic [VALUE_W-1:0]        total_uncertainty;
        logic                      zero_error_flag;
        logic                      single_flag;
        logic                      overflow_flag;
    } t_result;

endpackage

// ----- hdl/wmc_if.sv -----
// valid/ready channel interfaces for measurements and results
interface wmc_meas_if;
    logic           valid;
    logic           ready;
    wmc_pkg::t_meas data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wmc_result_if;
    logic             valid;
    logic             ready;
    wmc_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/weighted_measurement_combiner_top.sv -----
// Weighted measurement combiner: takes measurements (value, statistical error,
// systematic error) over a valid/ready channel and gives one result per group on
// the item marked last. An item with a nonzero statistical error passes through
// a shift-add square of the error, the bit-serial divider for the weight
// 2^(2F+16)/s^2 and a shift-add product w*v, plus the accept and accumulate
// steps. An item with a zero error or one past capacity needs only the accept
// step. The closing item adds the mean division, the reciprocal division and its
// square root (all three skipped after a zero error or with a zero weight sum),
// a sum of squares over the stored values (when more than one value is stored),
// the spread division and two more square roots. One item is in flight at a
// time; the result register frees the input side as soon as the result is
// loaded, and a result still waiting holds the next group in its last square
// root until it is taken.
module weighted_measurement_combiner_top #(
    parameter int unsigned MAX_MEASUREMENTS = 8,
    parameter int unsigned FRAC_BITS        = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    wmc_meas_if.sink           i_meas,
    wmc_result_if.source       o_result
);
    localparam int unsigned W      = wmc_pkg::ACC_W;
    localparam int unsigned CNT_W  = $clog2(MAX_MEASUREMENTS + 1);
    localparam int unsigned IDX_W  = (MAX_MEASUREMENTS > 1) ? $clog2(MAX_MEASUREMENTS) : 1;
    localparam int unsigned WSHIFT = 2 * FRAC_BITS + 16;
    localparam logic [W-1:0] ONE_W = W'(1) << WSHIFT;

    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000_0000_0000_0001,
        S_SQ     = 16'b0000_0000_0000_0010,
        S_WDIV   = 16'b0000_0000_0000_0100,
        S_WMUL   = 16'b0000_0000_0000_1000,
        S_ACC    = 16'b0000_0000_0001_0000,
        S_MDIV   = 16'b0000_0000_0010_0000,
        S_RDIV   = 16'b0000_0000_0100_0000,
        S_RSQRT  = 16'b0000_0000_1000_0000,
        S_SUMSQ  = 16'b0000_0001_0000_0000,
        S_SPREAD = 16'b0000_0010_0000_0000,
        S_SDIV   = 16'b0000_0100_0000_0000,
        S_SSQRT  = 16'b0000_1000_0000_0000,
        S_TMUL   = 16'b0001_0000_0000_0000,
        S_TSQRT  = 16'b0010_0000_0000_0000,
        S_OUT    = 16'b0100_0000_0000_0000,
        S_MULW   = 16'b1000_0000_0000_0000
    } t_state;

    t_state r_state;

    logic signed [15:0] r_store [MAX_MEASUREMENTS];
    logic [CNT_W-1:0]   r_count;
    logic [W-1:0]       r_wsum;
    logic signed [W-1:0] r_wvsum;
    logic signed [19+IDX_W:0] r_vsum;
    logic [19+IDX_W:0]  r_ssum;
    logic               r_zero;
    logic               r_ovf;

    wmc_pkg::t_meas     r_item;
    wmc_pkg::t_result   r_res;
    logic               r_res_valid;

    // shift-add multiplier: r_ma * r_mb, multiplier bits consumed lsb first
    logic [W-1:0]       r_ma;
    logic [W-1:0]       r_mb;
    logic [W-1:0]       r_mp;
    logic [6:0]         r_mcnt;
    logic               r_mneg;
    logic [W-1:0]       r_t0;
    logic [W-1:0]       r_t1;
    logic [IDX_W:0]     r_idx;
    logic signed [15:0] r_rd;
    logic signed [15:0] r_mean;
    logic [15:0]        r_stat;
    logic [15:0]        r_syst;
    logic               r_mneg_q;

    logic               r_div_start;
    logic               r_sq_start;
    logic [W-1:0]       r_div_num;
    logic [W-1:0]       r_div_den;
    logic [W-1:0]       r_sq_rad;
    logic               w_div_done;
    logic [W-1:0]       w_div_q;
    logic               w_sq_done;
    logic [W/2-1:0]     w_sq_root;

    logic               w_accept;
    logic               w_out_take;
    logic [W-1:0]       n_mp;
    logic [W-1:0]       n_sum;
    logic signed [W:0]  n_sat;
    logic [W-1:0]       n_mag;
    logic [W-1:0]       w_cnt;

    wmc_divider #(.WIDTH(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_num(r_div_num), .i_den(r_div_den), .o_done(w_div_done), .o_quot(w_div_q)
    );

    wmc_sqrt #(.WIDTH(W)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_sq_start),
        .i_rad(r_sq_rad), .o_done(w_sq_done), .o_root(w_sq_root)
    );

    assign w_accept     = i_meas.valid && i_meas.ready;
    assign w_out_take   = o_result.valid && o_result.ready;
    assign i_meas.ready = (r_state == S_IDLE);
    assign o_result.valid = r_res_valid;
    assign o_result.data  = r_res;
    assign w_cnt = W'(r_count);

    always_comb begin
        n_mp  = r_mb[0] ? (r_mp + r_ma) : r_mp;
        n_sum = 64'(r_wvsum) + r_t0;
        n_sat = 65'(r_wvsum) + 65'($signed(r_t0));
        n_mag = r_wvsum[W-1] ? (~r_wvsum + 1'b1) : r_wvsum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wsum      <= '0;
            r_wvsum     <= '0;
            r_vsum      <= '0;
            r_ssum      <= '0;
            r_zero      <= 1'b0;
            r_ovf       <= 1'b0;
            r_res_valid <= 1'b0;
            r_div_start <= 1'b0;
            r_sq_start  <= 1'b0;
            r_mcnt      <= '0;
        end else begin
            r_div_start <= 1'b0;
            r_sq_start  <= 1'b0;
            if (w_out_take) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_item <= i_meas.data;
                        if (r_count < CNT_W'(MAX_MEASUREMENTS)) begin
                            r_store[r_count[IDX_W-1:0]] <= i_meas.data.meas_value;
                            r_count <= r_count + 1'b1;
                            r_vsum  <= r_vsum + (20+IDX_W)'(i_meas.data.meas_value);
                            r_ssum  <= r_ssum + (20+IDX_W)'(i_meas.data.syst_error);
                            if (i_meas.data.stat_error == '0) begin
                                r_zero  <= 1'b1;
                                r_state <= i_meas.data.last_in_group ? S_MDIV : S_IDLE;
                            end else begin
                                r_ma    <= W'(i_meas.data.stat_error);
                                r_mb    <= W'(i_meas.data.stat_error);
                                r_mp    <= '0;
                                r_mcnt  <= 7'd16;
                                r_state <= S_SQ;
                            end
                        end else begin
                            r_ovf   <= 1'b1;
                            r_state <= i_meas.data.last_in_group ? S_MDIV : S_IDLE;
                        end
                    end
                end
                S_SQ: begin
                    r_mp   <= n_mp;
                    r_ma   <= r_ma << 1;
                    r_mb   <= r_mb >> 1;
                    r_mcnt <= r_mcnt - 1'b1;
                    if (r_mcnt == 7'd1) begin
                        r_div_num   <= ONE_W;
                        r_div_den   <= n_mp;
                        r_div_start <= 1'b1;
                        r_state     <= S_WDIV;
                    end
                end
                S_WDIV: begin
                    if (w_div_done) begin
                        r_wsum <= r_wsum + w_div_q;
                        r_ma   <= w_div_q;
                        r_mneg <= r_item.meas_value[15];
                        r_mb   <= r_item.meas_value[15] ?
                                  W'(-32'(r_item.meas_value)) : W'(r_item.meas_value);
                        r_mp   <= '0;
                        r_mcnt <= 7'd17;
                        r_state <= S_WMUL;
                    end
                end
                S_WMUL: begin
                    r_mp   <= n_mp;
                    r_ma   <= r_ma << 1;
                    r_mb   <= r_mb >> 1;
                    r_mcnt <= r_mcnt - 1'b1;
                    if (r_mcnt == 7'd1) begin
                        r_t0    <= r_mneg ? (~n_mp + 1'b1) : n_mp;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (n_sat[W] != n_sat[W-1]) begin
                        r_wvsum <= n_sat[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                    end else begin
                        r_wvsum <= n_sum;
                    end
                    r_state <= r_item.last_in_group ? S_MDIV : S_IDLE;
                end
                S_MDIV: begin
                    r_mneg_q <= r_wvsum[W-1];
                    if (!r_zero && r_wsum != '0) begin
                        r_div_num   <= n_mag;
                        r_div_den   <= r_wsum;
                        r_div_start <= 1'b1;
                        r_state     <= S_RDIV;
                    end else begin
                        r_mean  <= '0;
                        r_stat  <= '0;
                        r_t0    <= '0;
                        r_t1    <= '0;
                        r_idx   <= '0;
                        r_state <= S_SUMSQ;
                    end
                end
                S_RDIV: begin
                    if (w_div_done) begin
                        if (r_mneg_q) begin
                            r_mean <= (w_div_q > W'(32768)) ? 16'sh8000 :
                                      16'(~w_div_q[15:0] + 1'b1);
                        end else begin
                            r_mean <= (w_div_q > W'(32767)) ? 16'sh7fff :
                                      w_div_q[15:0];
                        end
                        r_div_num   <= ONE_W;
                        r_div_den   <= r_wsum;
                        r_div_start <= 1'b1;
                        r_state     <= S_RSQRT;
                    end
                end
                S_RSQRT: begin
                    if (w_div_done) begin
                        r_sq_rad   <= w_div_q;
                        r_sq_start <= 1'b1;
                    end
                    if (w_sq_done) begin
                        r_stat  <= (w_sq_root > (W/2)'(65535)) ? 16'hffff : w_sq_root[15:0];
                        r_t0    <= '0;
                        r_t1    <= '0;
                        r_idx   <= '0;
                        r_state <= S_SUMSQ;
                    end
                end
                S_SUMSQ: begin
                    // sum of squares over stored values, one multiply per entry
                    if (r_count <= CNT_W'(1)) begin
                        r_div_num   <= 64'(r_ssum) * 64'(r_ssum);
                        r_div_den   <= W'(1);
                        r_div_start <= 1'b1;
                        r_state     <= S_SDIV;
                    end else if (r_idx == (IDX_W+1)'(r_count)) begin
                        r_ma    <= r_t0;
                        r_mb    <= w_cnt;
                        r_mp    <= '0;
                        r_mcnt  <= 7'd8;
                        r_state <= S_MULW;
                    end else begin
                        r_rd    <= r_store[r_idx[IDX_W-1:0]];
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SPREAD;
                    end
                end
                S_SPREAD: begin
                    r_t0    <= r_t0 + W'(32'(r_rd) * 32'(r_rd));
                    r_state <= S_SUMSQ;
                end
                S_MULW: begin
                    // n * sumsq, then spread numerator
                    r_mp   <= n_mp;
                    r_ma   <= r_ma << 1;
                    r_mb   <= r_mb >> 1;
                    r_mcnt <= r_mcnt - 1'b1;
                    if (r_mcnt == 7'd1) begin
                        r_t1    <= n_mp;
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    if (r_mcnt == 7'd0) begin
                        // a = max(n*sumsq - vsum^2, 0)
                        r_t0   <= W'(r_vsum[19+IDX_W] ? -r_vsum : r_vsum);
                        r_mcnt <= 7'd1;
                    end else if (r_mcnt == 7'd1) begin
                        r_t0   <= W'(r_t0[31:0]) * W'(r_t0[31:0]);
                        r_mcnt <= 7'd2;
                    end else if (r_mcnt == 7'd2) begin
                        r_t1   <= (r_t1 > r_t0) ? (r_t1 - r_t0) : '0;
                        r_mcnt <= 7'd3;
                    end else if (r_mcnt == 7'd3) begin
                        r_t1   <= W'(r_t1 * W'(r_count));
                        r_t0   <= W'(r_ssum) * W'(r_ssum);
                        r_mcnt <= 7'd4;
                    end else if (r_mcnt == 7'd4) begin
                        r_t0   <= W'(r_t0 * W'(r_count - 1'b1));
                        r_mcnt <= 7'd5;
                    end else begin
                        r_div_num   <= r_t1 + r_t0;
                        r_div_den   <= W'(32'(r_count) * 32'(r_count) *
                                          32'(r_count - 1'b1));
                        r_div_start <= 1'b1;
                        r_state     <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    if (w_div_done) begin
                        r_sq_rad   <= w_div_q;
                        r_sq_start <= 1'b1;
                        r_state    <= S_SSQRT;
                    end
                end
                S_SSQRT: begin
                    if (w_sq_done) begin
                        r_syst         <= (w_sq_root > (W/2)'(65535)) ? 16'hffff :
                                          w_sq_root[15:0];
                        r_sq_rad       <= W'(32'(r_stat) * 32'(r_stat)) +
                                          W'(32'((w_sq_root > (W/2)'(65535)) ? 16'hffff :
                                          w_sq_root[15:0]) * 32'((w_sq_root > (W/2)'(65535))
                                          ? 16'hffff : w_sq_root[15:0]));
                        r_sq_start     <= 1'b1;
                        r_state        <= S_TSQRT;
                    end
                end
                S_TSQRT: begin
                    if (w_sq_done && !r_res_valid) begin
                        r_res.weighted_mean     <= r_mean;
                        r_res.stat_uncertainty  <= r_stat;
                        r_res.syst_uncertainty  <= r_syst;
                        r_res.total_uncertainty <= (w_sq_root > (W/2)'(65535)) ? 16'hffff :
                                                   w_sq_root[15:0];
                        r_res.zero_error_flag   <= r_zero;
                        r_res.single_flag       <= (r_count == CNT_W'(1));
                        r_res.overflow_flag     <= r_ovf;
                        r_state                 <= S_OUT;
                    end else if (w_sq_done) begin
                        r_sq_start <= 1'b1;
                    end
                end
                S_OUT: begin
                    r_res_valid <= 1'b1;
                    r_count <= '0;
                    r_wsum  <= '0;
                    r_wvsum <= '0;
                    r_vsum  <= '0;
                    r_ssum  <= '0;
                    r_zero  <= 1'b0;
                    r_ovf   <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "weighted_measurement_combiner_top_macros.svh"

    `WMC_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_MEASUREMENTS))
    `WMC_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, i_meas.ready, r_state == S_IDLE)
    `WMC_ASSERT_NEXT(a_out_clears, i_clk, i_rst_n, r_state == S_OUT, r_count == '0 && r_res_valid)
    `WMC_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_state == S_OUT, !r_res_valid)
endmodule

// ----- hdl/wmc_divider.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module wmc_divider #(
    parameter int unsigned WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_num,
    input  logic [WIDTH-1:0] i_den,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quot
);
    localparam int unsigned CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_quot;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [WIDTH:0]   n_trial;
    logic [WIDTH:0]   n_shift;

    always_comb begin
        n_shift = {r_rem, r_quot[WIDTH-1]};
        n_trial = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!n_trial[WIDTH]) begin
                r_rem  <= n_trial[WIDTH-1:0];
                r_quot <= {r_quot[WIDTH-2:0], 1'b1};
            end else begin
                r_rem  <= n_shift[WIDTH-1:0];
                r_quot <= {r_quot[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ----- hdl/wmc_sqrt.sv -----
// digit-by-digit integer square root, one result bit per cycle
module wmc_sqrt #(
    parameter int unsigned WIDTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [WIDTH-1:0]   i_rad,
    output logic               o_done,
    output logic [WIDTH/2-1:0] o_root
);
    localparam int unsigned HW = WIDTH / 2;
    localparam int unsigned CW = $clog2(HW + 1);

    logic [WIDTH-1:0] r_rad;
    logic [HW+1:0]    r_rem;
    logic [HW-1:0]    r_root;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [HW+1:0]    n_rem;
    logic [HW+1:0]    n_trial;

    always_comb begin
        n_rem   = {r_rem[HW-1:0], r_rad[WIDTH-1 -: 2]};
        n_trial = n_rem - {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(HW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[WIDTH-3:0], 2'b00};
            if (!n_trial[HW+1]) begin
                r_rem  <= n_trial;
                r_root <= {r_root[HW-2:0], 1'b1};
            end else begin
                r_rem  <= n_rem;
                r_root <= {r_root[HW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
